@@ rtl/core/vector_alu_2d_macros.svh @@
// ----------------------------------------------------------------------------
// vector_alu_2d_macros.svh
// Assertion macros shared by the vector unit. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ALU_2D_MACROS_SVH
`define VECTOR_ALU_2D_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VAU_CHECK(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VAU_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/vau_pkg.sv @@
// ----------------------------------------------------------------------------
// vau_pkg
// Types, constants and step functions of the 2D fixed-point vector unit.
// ----------------------------------------------------------------------------
package vau_pkg;

  localparam int CW = 32;             // component width
  localparam int FB = 16;             // fraction bits
  localparam int MW = 48;             // magnitude width
  localparam int PW = 2 * CW;         // full product width
  localparam int RW = 2 * CW;         // square root radicand width
  localparam int QW = CW + FB;        // quotient width

  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = CW / SQ_STEPS;
  localparam int SQ_REM_W  = CW + 3;

  localparam int DV_STEPS  = 3;
  localparam int DV_STAGES = QW / DV_STEPS;
  localparam int DV_REM_W  = CW + 1;

  localparam int PRE_STAGES = 3;
  localparam int NUM_STAGES = PRE_STAGES + SQ_STAGES + DV_STAGES;
  localparam int DV_FIRST   = PRE_STAGES + SQ_STAGES;

  localparam logic signed [CW-1:0] MAX_VAL = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_VAL = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE_VAL = {{(CW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic signed [CW:0]   SUM_HI  = {2'b00, {(CW-1){1'b1}}};
  localparam logic signed [CW:0]   SUM_LO  = {2'b11, {(CW-1){1'b0}}};
  localparam logic [MW-1:0]        MAG_MAX = {MW{1'b1}};

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_SCALE = 4'd2,
    MODE_DIV   = 4'd3,
    MODE_CMP   = 4'd4,
    MODE_SQLEN = 4'd5,
    MODE_LEN   = 4'd6,
    MODE_NORM  = 4'd7,
    MODE_SIGN  = 4'd8
  } mode_t;

  typedef struct packed {
    logic [3:0]           mode;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] scalar;
  } cmd_t;

  typedef struct packed {
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic [MW-1:0]        magnitude;
    logic                 equal;
    logic                 overflow;
    logic                 div_zero;
  } rsp_t;

  typedef struct packed {
    logic                 ovf;
    logic signed [CW-1:0] val;
  } sat_t;

  typedef struct packed {
    logic [RW-1:0]       rad;
    logic [SQ_REM_W-1:0] rem;
    logic [CW-1:0]       root;
  } sq_t;

  typedef struct packed {
    logic [QW-1:0]       num;
    logic [DV_REM_W-1:0] rem;
    logic [QW-1:0]       q;
  } dv_t;

  // Signed component from sign and magnitude, clamped to the component range.
  function automatic sat_t sat_mag(input logic neg, input logic [PW-1:0] m);
    sat_t r;
    logic [PW-1:0] lim;
    lim   = PW'(1) << (CW - 1);
    r.ovf = 1'b0;
    if (neg) begin
      if (m > lim) begin
        r.ovf = 1'b1;
        r.val = MIN_VAL;
      end else begin
        r.val = -$signed(m[CW-1:0]);
      end
    end else if (m > lim - PW'(1)) begin
      r.ovf = 1'b1;
      r.val = MAX_VAL;
    end else begin
      r.val = $signed(m[CW-1:0]);
    end
    return r;
  endfunction

  // Clamp a sum that has one extra bit of headroom.
  function automatic sat_t sat_sum(input logic signed [CW:0] s);
    sat_t r;
    r.ovf = 1'b0;
    r.val = s[CW-1:0];
    if (s > SUM_HI) begin
      r.ovf = 1'b1;
      r.val = MAX_VAL;
    end else if (s < SUM_LO) begin
      r.ovf = 1'b1;
      r.val = MIN_VAL;
    end
    return r;
  endfunction

  // Restoring square root, SQ_STEPS result bits per call.
  function automatic sq_t sq_step(input sq_t s);
    sq_t r;
    logic [SQ_REM_W-1:0] trial;
    r = s;
    for (int k = 0; k < SQ_STEPS; k++) begin
      r.rem = {r.rem[SQ_REM_W-3:0], r.rad[RW-1:RW-2]};
      r.rad = r.rad << 2;
      trial = SQ_REM_W'({r.root, 2'b01});
      if (r.rem >= trial) begin
        r.rem  = r.rem - trial;
        r.root = {r.root[CW-2:0], 1'b1};
      end else begin
        r.root = {r.root[CW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Restoring division, DV_STEPS quotient bits per call.
  function automatic dv_t dv_step(input dv_t s, input logic [CW-1:0] d);
    dv_t r;
    logic [DV_REM_W-1:0] dd;
    r  = s;
    dd = {1'b0, d};
    for (int k = 0; k < DV_STEPS; k++) begin
      r.rem = {r.rem[DV_REM_W-2:0], r.num[QW-1]};
      r.num = r.num << 1;
      if (r.rem >= dd) begin
        r.rem = r.rem - dd;
        r.q   = {r.q[QW-2:0], 1'b1};
      end else begin
        r.q   = {r.q[QW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/vector_alu_2d.sv @@
// ----------------------------------------------------------------------------
// vector_alu_2d
// Pipelined 2D vector unit in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: each item on the cmd channel (cmd_valid/cmd_ready, payload cmd)
// carries a mode, vectors a and b and a scalar, and yields exactly one item
// on the rsp channel (rsp_valid/rsp_ready, payload rsp), in order.
// Throughput is one item per cycle while the skid register is not full. Every
// item takes the same path: input register, multipliers, square sum, a
// 16-stage square root and a 16-stage divider; all modes share it.
// When rsp_ready is low the held result stays on rsp and the next finished
// item drops into a one-entry skid register; cmd_ready falls only while
// that skid register is full, and the whole pipeline then freezes in place.
// Reset (rst, synchronous) empties the pipeline and the output registers;
// no results are in flight after it.
// ----------------------------------------------------------------------------
`include "vector_alu_2d_macros.svh"

module vector_alu_2d import vau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int LAST = NUM_STAGES - 1;

  // Per-item side information that travels alongside the arithmetic.
  typedef struct packed {
    logic [3:0]    mode;
    logic          neg_x;
    logic          neg_y;
    logic          s_neg;
    logic          s_zero;
    logic          ax_zero;
    logic          ay_zero;
    logic [CW-1:0] amx;
    logic [CW-1:0] amy;
    logic [CW-1:0] sm;
    rsp_t          early;
  } side_t;

  logic                  en;
  logic                  skid_full;
  logic                  leave;
  logic [NUM_STAGES-1:0] vld;

  cmd_t          p0;
  side_t         side [1:LAST];
  logic [PW-1:0] px, py, sqx, sqy;
  logic [RW-1:0] rad;
  logic [CW-1:0] root;
  logic [QW-1:0] qx, qy;

  side_t s1_next, s2_next, s_dv;
  sat_t  add_x, add_y, scl_x, scl_y, fx, fy;
  logic signed [CW:0] ex_ax, ex_ay, ex_bx, ex_by;
  logic [RW-1:0] sq_sum, sq_shift;
  logic [QW-1:0] nx, ny;
  logic [CW-1:0] den;
  logic          dv_neg;
  rsp_t fin, skid;

  // The pipeline moves as one unit; it stops only when the skid is full.
  assign en        = !skid_full;
  assign cmd_ready = en;
  assign leave     = en && vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], cmd_valid};
    end
  end

  // Stage 1: magnitudes, signs and the add, subtract, compare and sign results.
  always_comb begin
    ex_ax = p0.ax;
    ex_ay = p0.ay;
    ex_bx = p0.bx;
    ex_by = p0.by;
    if (p0.mode == MODE_SUB) begin
      add_x = sat_sum(ex_ax - ex_bx);
      add_y = sat_sum(ex_ay - ex_by);
    end else begin
      add_x = sat_sum(ex_ax + ex_bx);
      add_y = sat_sum(ex_ay + ex_by);
    end
    s1_next.mode    = p0.mode;
    s1_next.neg_x   = p0.ax[CW-1];
    s1_next.neg_y   = p0.ay[CW-1];
    s1_next.s_neg   = p0.scalar[CW-1];
    s1_next.s_zero  = (p0.scalar == '0);
    s1_next.ax_zero = (p0.ax == '0);
    s1_next.ay_zero = (p0.ay == '0);
    s1_next.amx     = p0.ax[CW-1] ? CW'(-p0.ax) : CW'(p0.ax);
    s1_next.amy     = p0.ay[CW-1] ? CW'(-p0.ay) : CW'(p0.ay);
    s1_next.sm      = p0.scalar[CW-1] ? CW'(-p0.scalar) : CW'(p0.scalar);
    s1_next.early   = '0;
    unique case (p0.mode) inside
      MODE_ADD, MODE_SUB: begin
        s1_next.early.rx       = add_x.val;
        s1_next.early.ry       = add_y.val;
        s1_next.early.overflow = add_x.ovf | add_y.ovf;
      end
      MODE_CMP: begin
        s1_next.early.equal = (p0.ax == p0.bx) && (p0.ay == p0.by);
      end
      MODE_SIGN: begin
        if (p0.ax != '0) begin
          s1_next.early.rx = p0.ax[CW-1] ? -ONE_VAL : ONE_VAL;
        end
        if (p0.ay != '0) begin
          s1_next.early.ry = p0.ay[CW-1] ? -ONE_VAL : ONE_VAL;
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 2: scale results, squared length and the radicand.
  always_comb begin
    sq_sum   = sqx + sqy;
    sq_shift = sq_sum >> FB;
    scl_x    = sat_mag(side[1].neg_x ^ side[1].s_neg, px >> FB);
    scl_y    = sat_mag(side[1].neg_y ^ side[1].s_neg, py >> FB);
    s2_next  = side[1];
    if (side[1].mode == MODE_SCALE) begin
      s2_next.early.rx       = scl_x.val;
      s2_next.early.ry       = scl_y.val;
      s2_next.early.overflow = scl_x.ovf | scl_y.ovf;
    end
    if (side[1].mode == MODE_SQLEN) begin
      s2_next.early.magnitude = (sq_shift > RW'(MAG_MAX)) ? MAG_MAX : MW'(sq_shift);
    end
  end

  // Entry of the divider: length result and divisor choice.
  always_comb begin
    s_dv = side[DV_FIRST-1];
    if (side[DV_FIRST-1].mode == MODE_LEN) begin
      s_dv.early.magnitude = MW'(root);
    end
    nx  = {side[DV_FIRST-1].amx, {FB{1'b0}}};
    ny  = {side[DV_FIRST-1].amy, {FB{1'b0}}};
    den = (side[DV_FIRST-1].mode == MODE_NORM) ? root : side[DV_FIRST-1].sm;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0      <= cmd;
      side[1] <= s1_next;
      px      <= s1_next.amx * s1_next.sm;
      py      <= s1_next.amy * s1_next.sm;
      sqx     <= s1_next.amx * s1_next.amx;
      sqy     <= s1_next.amy * s1_next.amy;
      side[2] <= s2_next;
      rad     <= sq_sum;
      for (int k = 3; k <= LAST; k++) begin
        if (k != DV_FIRST) begin
          side[k] <= side[k-1];
        end
      end
      side[DV_FIRST] <= s_dv;
    end
  end

  vau_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (root)
  );

  vau_div u_div (
    .clk (clk),
    .en  (en),
    .nx  (nx),
    .ny  (ny),
    .den (den),
    .qx  (qx),
    .qy  (qy)
  );

  // Final stage: divide and normalize results from the quotients.
  // Only a divide takes the sign of the scalar; a length is never negative.
  always_comb begin
    dv_neg = (side[LAST].mode == MODE_DIV) && side[LAST].s_neg;
    fx  = sat_mag(side[LAST].neg_x ^ dv_neg, PW'(qx));
    fy  = sat_mag(side[LAST].neg_y ^ dv_neg, PW'(qy));
    fin = side[LAST].early;
    unique case (side[LAST].mode) inside
      MODE_DIV: begin
        if (side[LAST].s_zero) begin
          // Division by zero saturates by the sign of the numerator; a zero component stays zero.
          fin.div_zero = 1'b1;
          fin.rx = side[LAST].ax_zero ? '0 : (side[LAST].neg_x ? MIN_VAL : MAX_VAL);
          fin.ry = side[LAST].ay_zero ? '0 : (side[LAST].neg_y ? MIN_VAL : MAX_VAL);
        end else begin
          fin.rx       = fx.val;
          fin.ry       = fy.val;
          fin.overflow = fx.ovf | fy.ovf;
        end
      end
      MODE_NORM: begin
        // A zero vector normalizes to zero; the divisor is positive here.
        if (!(side[LAST].ax_zero && side[LAST].ay_zero)) begin
          fin.rx       = fx.val;
          fin.ry       = fy.val;
          fin.overflow = fx.ovf | fy.ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      if (skid_full) begin
        rsp_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        rsp_valid <= leave;
      end
    end else if (leave) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_ready) begin
      rsp <= skid_full ? skid : fin;
    end else if (leave) begin
      skid <= fin;
    end
  end

  `VAU_CHECK(a_dz_no_ovf, rsp_valid && rsp.div_zero, !rsp.overflow, "div_zero with overflow")
  `VAU_CHECK(a_stall_held, !cmd_ready, rsp_valid, "stall without result")
  `VAU_CHECK(a_eq_only, rsp_valid && rsp.equal, rsp.rx == '0 && rsp.ry == '0 && rsp.magnitude == '0, "equal with data")
  `VAU_CHECK_NEXT(a_skid_drain, !cmd_ready && rsp_ready, cmd_ready, "skid did not drain")

endmodule

@@ rtl/core/vau_isqrt.sv @@
// ----------------------------------------------------------------------------
// vau_isqrt
// Pipelined integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module vau_isqrt import vau_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rad,
  output logic [CW-1:0] root
);

  sq_t st [SQ_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sq_step('{rad: rad, rem: '0, root: '0});
      for (int j = 1; j < SQ_STAGES; j++) begin
        st[j] <= sq_step(st[j-1]);
      end
    end
  end

  assign root = st[SQ_STAGES-1].root;

endmodule

@@ rtl/core/vau_div.sv @@
// ----------------------------------------------------------------------------
// vau_div
// Pipelined unsigned divider for both components, three quotient bits per stage.
// ----------------------------------------------------------------------------
module vau_div import vau_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] nx,
  input  logic [QW-1:0] ny,
  input  logic [CW-1:0] den,
  output logic [QW-1:0] qx,
  output logic [QW-1:0] qy
);

  dv_t           xs [DV_STAGES];
  dv_t           ys [DV_STAGES];
  logic [CW-1:0] ds [DV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= dv_step('{num: nx, rem: '0, q: '0}, den);
      ys[0] <= dv_step('{num: ny, rem: '0, q: '0}, den);
      ds[0] <= den;
      for (int j = 1; j < DV_STAGES; j++) begin
        xs[j] <= dv_step(xs[j-1], ds[j-1]);
        ys[j] <= dv_step(ys[j-1], ds[j-1]);
        ds[j] <= ds[j-1];
      end
    end
  end

  assign qx = xs[DV_STAGES-1].q;
  assign qy = ys[DV_STAGES-1].q;

endmodule
